// ===== rtl/vector3_normalize_macros.svh =====
// ----------------------------------------------------------------------------
// vector3_normalize_macros: assertion helpers of the vector normalizer
// Clocked implication checks that are switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the vector normalizer
// Fixed output format, search length and queue status type.
// ----------------------------------------------------------------------------
package vn_pkg;

    // Output components are signed Q1.14 in 16 bits.
    localparam int UNIT_BITS = 16;
    // One search step per magnitude bit of the result.
    localparam int STEPS = UNIT_BITS - 1;
    localparam int UNIT_ONE = 16384;
    // Scale of the squared target: (2u-1)^2 * S <= c^2 * 2^30.
    localparam int FRAC_SHIFT = 30;
    localparam int QUEUE_DEPTH = 4;

    // Status of the queue as seen by the front and back parts.
    typedef struct packed {
        logic has_item;
        logic has_room;
    } t_queue_stat;

endpackage

// ===== rtl/vn_ifs.sv =====
// ----------------------------------------------------------------------------
// vn_ifs: valid/ready channels of the vector normalizer
// Input vector channel and unit vector result channel.
// ----------------------------------------------------------------------------
interface vn_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] comp_x;
    logic signed [W-1:0] comp_y;
    logic signed [W-1:0] comp_z;

    modport source (output valid, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_x;
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_y;
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_z;
    logic                                zero_length;

    modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

// ===== rtl/vn_front.sv =====
// ----------------------------------------------------------------------------
// vn_front: input stage of the vector normalizer
// Takes magnitudes and signs, squares them and forms the sum of squares.
// ----------------------------------------------------------------------------
module vn_front #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vn_in_if.sink                 i_in,
    input  vn_pkg::t_queue_stat   i_stat,
    output logic                  o_push,
    output logic [8*W+2:0]        o_entry
);
    localparam int SW = 2 * W;

    logic [W-1:0]  mag [3];
    logic [2:0]    neg;
    logic          accept;

    logic          r_vld;
    logic [2:0]    r_neg;
    logic [SW-1:0] r_sq [3];
    logic [SW-1:0] sum;

    // Accept only when the queue can absorb this item next cycle.
    assign i_in.ready = i_stat.has_room;
    assign accept     = i_in.valid && i_in.ready;

    // Sign and magnitude of each component.
    always_comb begin
        neg[0] = i_in.comp_x[W-1];
        neg[1] = i_in.comp_y[W-1];
        neg[2] = i_in.comp_z[W-1];
        mag[0] = neg[0] ? (~i_in.comp_x + 1'b1) : i_in.comp_x;
        mag[1] = neg[1] ? (~i_in.comp_y + 1'b1) : i_in.comp_y;
        mag[2] = neg[2] ? (~i_in.comp_z + 1'b1) : i_in.comp_z;
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    // Squares, registered after the multipliers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= neg;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SW'(mag[i]) * SW'(mag[i]);
            end
        end
    end

    // The sum of three squares never exceeds 3 * 2^(2W-2), so it fits 2W bits.
    assign sum     = r_sq[0] + r_sq[1] + r_sq[2];
    assign o_push  = r_vld;
    assign o_entry = {sum, r_sq[2], r_sq[1], r_sq[0], r_neg};

endmodule

// ===== rtl/vn_queue.sv =====
// ----------------------------------------------------------------------------
// vn_queue: short item queue between front and back
// Lets the input side keep accepting while the result side stalls.
// ----------------------------------------------------------------------------
module vn_queue #(
    parameter int EW = 131
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [EW-1:0]       i_entry,
    input  logic                i_pop,
    output logic [EW-1:0]       o_head,
    output vn_pkg::t_queue_stat o_stat
);
    localparam int DEPTH = vn_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head = r_mem[r_rd];

    // Room is reserved for the item already in flight in the front.
    always_comb begin
        o_stat.has_item = (r_count != '0);
        o_stat.has_room = ((r_count + CW'(i_push)) < CW'(DEPTH));
    end

endmodule

// ===== rtl/vn_back.sv =====
// ----------------------------------------------------------------------------
// vn_back: pipelined unit-length search of the vector normalizer
// One stage per result bit decides (2u-1)^2 * S <= c^2 * 2^30 incrementally.
// ----------------------------------------------------------------------------
`include "vector3_normalize_macros.svh"

module vn_back #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8*W+2:0]      i_entry,
    input  vn_pkg::t_queue_stat i_stat,
    output logic                o_pop,
    vn_out_if.source            o_out
);
    localparam int SW = 2 * W;
    localparam int PW = 2 * W + 34;
    localparam int NS = vn_pkg::STEPS;
    localparam int L  = NS - 1;

    logic                 en;
    logic [SW-1:0]        e_s;
    logic [SW-1:0]        e_sq [3];
    logic [2:0]           e_neg;

    logic                 r_vld [NS];
    logic [2:0]           r_neg [NS];
    logic [SW-1:0]        r_s   [NS];
    logic signed [PW-1:0] r_r   [NS][3];
    logic signed [PW-1:0] r_p   [NS][3];
    logic signed [PW-1:0] r_q   [NS][3];
    logic [NS-1:0]        r_u   [NS][3];

    logic                 zero;
    logic [NS-1:0]        u_out [3];
    logic signed [vn_pkg::UNIT_BITS-1:0] unit [3];

    // Unpack the queue head.
    assign e_neg   = i_entry[2:0];
    assign e_sq[0] = i_entry[3 +: SW];
    assign e_sq[1] = i_entry[3 + SW +: SW];
    assign e_sq[2] = i_entry[3 + 2*SW +: SW];
    assign e_s     = i_entry[3 + 3*SW +: SW];

    // The whole pipeline advances unless a finished item is waiting.
    assign en    = !r_vld[L] || o_out.ready;
    assign o_pop = en && i_stat.has_item;

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_stat.has_item;
            for (int j = 1; j < NS; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Search stages: stage j decides result bit NS-1-j.
    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;

        logic [2:0]           in_neg;
        logic [SW-1:0]        in_s;
        logic signed [PW-1:0] in_sx;

        if (j == 0) begin : g_first
            assign in_neg = e_neg;
            assign in_s   = e_s;
        end else begin : g_rest
            assign in_neg = r_neg[j-1];
            assign in_s   = r_s[j-1];
        end
        assign in_sx = signed'({{(PW-SW){1'b0}}, in_s});

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic signed [PW-1:0] in_r;
            logic signed [PW-1:0] in_p;
            logic signed [PW-1:0] in_q;
            logic [NS-1:0]        in_u;
            logic signed [PW-1:0] cand;
            logic                 take;

            // Start of the search: T = -1, so T^2*S = S and T*S = -S.
            if (j == 0) begin : g_init
                assign in_r = signed'({{(PW-SW){1'b0}}, e_sq[l]}) <<< vn_pkg::FRAC_SHIFT;
                assign in_p = in_sx;
                assign in_q = -in_sx;
                assign in_u = '0;
            end else begin : g_next
                assign in_r = r_r[j-1][l];
                assign in_p = r_p[j-1][l];
                assign in_q = r_q[j-1][l];
                assign in_u = r_u[j-1][l];
            end

            // Candidate (T + 2^(K+1))^2 * S from the running terms.
            assign cand = in_p + (in_q <<< (K + 2)) + (in_sx <<< (2 * K + 2));
            assign take = (cand <= in_r);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_r[j][l] <= in_r;
                    r_p[j][l] <= take ? cand : in_p;
                    r_q[j][l] <= take ? (in_q + (in_sx <<< (K + 1))) : in_q;
                    r_u[j][l] <= in_u | (NS'(take) << K);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_neg[j] <= in_neg;
                r_s[j]   <= in_s;
            end
        end
    end

    // Sign and zero handling on the last stage.
    assign zero = (r_s[L] == '0);
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            u_out[l] = r_u[L][l];
            if (zero) begin
                unit[l] = '0;
            end else if (r_neg[L][l]) begin
                unit[l] = -signed'({1'b0, u_out[l]});
            end else begin
                unit[l] = signed'({1'b0, u_out[l]});
            end
        end
    end

    assign o_out.valid       = r_vld[L];
    assign o_out.unit_x      = unit[0];
    assign o_out.unit_y      = unit[1];
    assign o_out.unit_z      = unit[2];
    assign o_out.zero_length = zero;

    // A zero-length result carries zero components.
    `VN_ASSERT_NOW(a_zero_out, i_clk, i_rst_n, o_out.valid && o_out.zero_length, o_out.unit_x == '0 && o_out.unit_y == '0 && o_out.unit_z == '0, "zero vector with nonzero components")
    // The first stage fills exactly when an item left the queue.
    `VN_ASSERT_NEXT(a_fill, i_clk, i_rst_n, en, r_vld[0] == $past(i_stat.has_item), "first stage valid does not follow the queue pop")
    // A stalled result holds its search state.
    `VN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_vld[L] && !o_out.ready, $stable(r_u[L][0]) && $stable(r_s[L]) && $stable(r_neg[L]), "stalled result changed")
    // A nonzero vector never gives a magnitude above one.
    `VN_ASSERT_NOW(a_range, i_clk, i_rst_n, r_vld[L] && !zero, r_u[L][0] <= NS'(vn_pkg::UNIT_ONE) && r_u[L][1] <= NS'(vn_pkg::UNIT_ONE) && r_u[L][2] <= NS'(vn_pkg::UNIT_ONE), "unit magnitude out of range")

endmodule

// ===== rtl/vector3_normalize.sv =====
// Path: square register, queue, then 15 search stages; each stage settles one result bit.
// Throughput: one vector per cycle unless the result side stalls the search pipeline.
// The four-entry queue keeps input accepted while the result side is stalled, until it fills.
// Reset: synchronous, active low; clears valid bits, queue pointers and fill level.
// ----------------------------------------------------------------------------
// vector3_normalize: 3D vector normalization to signed Q1.14
// Squares the components, queues the item, and finds each rounded unit
// component with a pipelined bitwise search on exact integer terms.
// ----------------------------------------------------------------------------
module vector3_normalize #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    vn_in_if.sink    i_in,
    vn_out_if.source o_out
);
    localparam int EW = 8 * COMPONENT_BITS + 3;

    logic                push;
    logic                pop;
    logic [EW-1:0]       entry;
    logic [EW-1:0]       head;
    vn_pkg::t_queue_stat stat;

    // Front: classify and square.
    vn_front #(.W(COMPONENT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (stat),
        .o_push  (push),
        .o_entry (entry)
    );

    // Queue between the two parts.
    vn_queue #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    // Back: unit-length search.
    vn_back #(.W(COMPONENT_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== verif/tb_vector3_normalize.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize: self-checking bench for the 3D vector normalizer
// Drives vectors over the valid/ready input channel and predicts each
// rounded Q1.14 unit vector with an exact integer search. Every result
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_x;
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_y;
    logic signed [vn_pkg::UNIT_BITS-1:0] unit_z;
    logic                                zero_length;
} t_unit_vec;

class unit_vec_board;
    t_unit_vec pending_q[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    // Rounded magnitude * 16384 / sqrt(sum), ties up, found by binary search.
    function automatic int unsigned scaled_mag(longint unsigned mag, longint unsigned sum);
        bit [127:0]   lhs;
        bit [127:0]   rhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        longint unsigned odd;
        lo = 0;
        hi = vn_pkg::UNIT_ONE;
        rhs = 128'(mag * mag) << vn_pkg::FRAC_SHIFT;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 64'(2 * mid - 1);
            lhs = 128'(odd * odd) * 128'(sum);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Work out the unit vector of an accepted input item.
    function void note_vector(logic signed [15:0] cx, logic signed [15:0] cy,
                              logic signed [15:0] cz);
        logic signed [15:0] comp[3];
        longint unsigned    mag[3];
        longint unsigned    sum;
        logic [15:0]        res[3];
        t_unit_vec          exp_vec;
        int unsigned        u;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = comp[i][15] ? longint'(17'h10000 - {1'b0, comp[i]}) : longint'(comp[i]);
            sum += mag[i] * mag[i];
        end
        if (sum == 0) begin
            exp_vec = '{'0, '0, '0, 1'b1};
        end else begin
            for (int i = 0; i < 3; i++) begin
                u = scaled_mag(mag[i], sum);
                res[i] = comp[i][15] ? 16'(-u) : 16'(u);
            end
            exp_vec = '{res[0], res[1], res[2], 1'b0};
        end
        pending_q.push_back(exp_vec);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Compare one accepted result with the oldest prediction.
    task check_result(t_unit_vec got);
        t_unit_vec want;
        if (pending_q.size() == 0) begin
            report("result with nothing expected");
            return;
        end
        want = pending_q.pop_front();
        if (got.unit_x !== want.unit_x)
            report($sformatf("unit_x got %0d want %0d", got.unit_x, want.unit_x));
        if (got.unit_y !== want.unit_y)
            report($sformatf("unit_y got %0d want %0d", got.unit_y, want.unit_y));
        if (got.unit_z !== want.unit_z)
            report($sformatf("unit_z got %0d want %0d", got.unit_z, want.unit_z));
        if (got.zero_length !== want.zero_length)
            report($sformatf("zero_length got %0b want %0b",
                             got.zero_length, want.zero_length));
    endtask
endclass

module tb_vector3_normalize;
    logic i_clk;
    logic i_rst_n;

    vn_in_if #(.W(16)) in_if();
    vn_out_if          out_if();

    vector3_normalize #(.COMPONENT_BITS(16)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    unit_vec_board board = new();
    int            src_idle_pct;
    int            snk_idle_pct;
    int            accepted_vecs;
    bit            long_hold_done;
    int            hold_left;

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.comp_x  = '0;
        in_if.comp_y  = '0;
        in_if.comp_z  = '0;
        out_if.ready  = 1'b0;
        accepted_vecs = 0;
        long_hold_done = 1'b0;
        hold_left     = 0;
        src_idle_pct  = 19;
        snk_idle_pct  = 47;
    end

    // Receiver: random stalls, plus one long hold-off once traffic is flowing.
    always @(negedge i_clk) begin
        if (!long_hold_done && accepted_vecs >= 500) begin
            long_hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Note accepted input items and check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            board.note_vector(in_if.comp_x, in_if.comp_y, in_if.comp_z);
            accepted_vecs++;
        end
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result('{out_if.unit_x, out_if.unit_y, out_if.unit_z,
                                 out_if.zero_length});
    end

    // Offer one vector and hold it until the block takes it.
    task send_vector(logic signed [15:0] cx, logic signed [15:0] cy, logic signed [15:0] cz);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid  = 1'b1;
        in_if.comp_x = cx;
        in_if.comp_y = cy;
        in_if.comp_z = cz;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Random component: full range, small, or extreme, with random sign, or zero.
    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(5))
            0, 1: return 16'($urandom);
            2:    return 16'($signed($urandom_range(0, 16)) - 8);
            3:    return 16'($signed($urandom_range(0, 512)) - 256);
            4:    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'sh0000;
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: zero vector, axes, extremes and exact ratios.
        send_vector(16'sd0, 16'sd0, 16'sd0);
        send_vector(16'sh7FFF, 16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sh8000, 16'sd0);
        send_vector(16'sd0, 16'sd0, 16'sh7FFF);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vector(16'sh7FFF, 16'sh8000, 16'sd0);
        send_vector(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_vector(16'sd1, 16'sd0, 16'sd0);
        send_vector(-16'sd1, 16'sd0, 16'sd0);
        send_vector(16'sd1, 16'sd1, 16'sd1);
        send_vector(-16'sd1, 16'sd1, -16'sd1);
        send_vector(16'sd1, 16'sd2, 16'sd2);
        send_vector(16'sd3, 16'sd4, 16'sd0);
        send_vector(-16'sd3, 16'sd0, -16'sd4);
        send_vector(16'sd2, 16'sd3, 16'sd6);
        send_vector(16'sd1, 16'sd1, 16'sd0);
        send_vector(16'sh8000, 16'sd1, 16'sd0);
        send_vector(16'sh7FFF, 16'sd1, -16'sd1);
        send_vector(16'sd0, 16'sd0, 16'sd0);

        // Random items over three idling mixes.
        for (int i = 0; i < 1950; i++) begin
            if (i == 650) begin
                src_idle_pct = 47;
                snk_idle_pct = 19;
            end else if (i == 1300) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            send_vector(rand_comp(), rand_comp(), rand_comp());
        end
        in_if.valid = 1'b0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
